[hdl/max_priority_queue_array_assert.svh]
// assertion macros for the max priority queue
`ifndef MAX_PRIORITY_QUEUE_ARRAY_ASSERT_SVH
`define MAX_PRIORITY_QUEUE_ARRAY_ASSERT_SVH

// same-cycle implication, checked out of reset
`define MPQA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mpqa same-cycle check failed");

// next-cycle implication, checked out of reset
`define MPQA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mpqa next-cycle check failed");

`endif

[hdl/mpqa_pkg.sv]
// shared types, codes and constants of the max priority queue
`default_nettype none

package mpqa_pkg;

    localparam int DATA_W        = 32;
    localparam int OCC_W         = 5;
    localparam int STATUS_W      = 2;
    localparam int CAPACITY_DEF  = 16;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    // command broadcast to every cell
    typedef struct packed {
        logic                     ins;
        logic                     rem;
        logic signed [DATA_W-1:0] value;
    } mpqa_cmd_t;

    // what a cell shows its neighbours
    typedef struct packed {
        logic                     valid;
        logic                     keep;
        logic signed [DATA_W-1:0] data;
    } mpqa_link_t;

endpackage

`default_nettype wire

[hdl/mpqa_cell.sv]
// one slot of the sorted shift-register queue
`default_nettype none

module mpqa_cell
    import mpqa_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire mpqa_cmd_t  cmd,
    input  wire mpqa_link_t left,
    input  wire mpqa_link_t right,
    output mpqa_link_t      link
);

    logic                     valid_reg;
    logic                     valid_next;
    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic                     keep;

    // slot holds its value on insert when it is at least the new one
    assign keep = valid_reg && (data_reg >= cmd.value);

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        priority if (cmd.ins)
        begin
            priority if (keep)
            begin
                valid_next = valid_reg;
            end
            else if (left.keep)
            begin
                valid_next = 1'b1;
                data_next  = cmd.value;
            end
            else
            begin
                valid_next = left.valid;
                data_next  = left.data;
            end
        end
        else if (cmd.rem)
        begin
            valid_next = right.valid;
            data_next  = right.data;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign link.valid = valid_reg;
    assign link.keep  = keep;
    assign link.data  = data_reg;

endmodule

`default_nettype wire

[hdl/max_priority_queue_array.sv]
// top level: bounded max priority queue built as a row of sorted cells
// registered: the result of an accepted request is in the output register from the next cycle
// throughput: one transaction per cycle while the output is not stalled; each cell resolves in a single compare
// against the broadcast value, so the row updates fully in every cycle
// reset: cell valid bits, fill count and output valid clear at once; slot data is
// left as is and needs no clearing pass
`default_nettype none

`include "max_priority_queue_array_assert.svh"

module max_priority_queue_array
    import mpqa_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       req_valid,
    output logic                            req_ready,
    input  wire logic                       action,
    input  wire logic signed [DATA_W-1:0]   value,
    output logic                            rsp_valid,
    input  wire logic                       rsp_ready,
    output logic signed [DATA_W-1:0]        removed_value,
    output logic [STATUS_W-1:0]             status,
    output logic [OCC_W-1:0]                occupancy,
    output logic                            is_empty,
    output logic                            is_full
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // boundary links: the head side always keeps, the tail side is empty
    localparam mpqa_link_t HEAD_LINK = '{valid: 1'b1, keep: 1'b1, data: '0};
    localparam mpqa_link_t TAIL_LINK = '{valid: 1'b0, keep: 1'b0, data: '0};

    // fill count
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             full;
    logic             empty;

    // output register
    logic                       rsp_valid_reg;
    logic                       rsp_valid_next;
    logic signed [DATA_W-1:0]   removed_value_reg;
    logic signed [DATA_W-1:0]   removed_value_next;
    logic [STATUS_W-1:0]        status_reg;
    logic [STATUS_W-1:0]        status_next;
    logic [OCC_W-1:0]           occupancy_reg;
    logic [OCC_W-1:0]           occupancy_next;
    logic                       is_empty_reg;
    logic                       is_empty_next;
    logic                       is_full_reg;
    logic                       is_full_next;

    logic       req_fire;
    mpqa_cmd_t  cmd;
    mpqa_link_t link_w [CAPACITY];

    assign full  = (count_reg == CAP_CNT);
    assign empty = (count_reg == '0);

    // a new request is taken whenever the output register is free or draining
    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign req_fire  = req_valid && req_ready;

    // rejected requests are not passed on to the cells
    assign cmd.ins   = req_fire && (action == ACT_INSERT) && !full;
    assign cmd.rem   = req_fire && (action == ACT_REMOVE) && !empty;
    assign cmd.value = value;

    // row of cells, kept sorted with the largest value in the head cell
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        mpqa_link_t left_w;
        mpqa_link_t right_w;

        if (i == 0)
        begin : g_head
            assign left_w = HEAD_LINK;
        end
        else
        begin : g_mid_left
            assign left_w = link_w[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_w = TAIL_LINK;
        end
        else
        begin : g_mid_right
            assign right_w = link_w[i+1];
        end

        mpqa_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (cmd),
            .left  (left_w),
            .right (right_w),
            .link  (link_w[i])
        );
    end

    // count update and result for the transaction being taken
    always_comb
    begin
        count_next         = count_reg;
        removed_value_next = removed_value_reg;
        status_next        = status_reg;
        rsp_valid_next     = rsp_valid_reg;

        if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        if (req_fire)
        begin
            rsp_valid_next     = 1'b1;
            removed_value_next = '0;
            status_next        = STATUS_OK;
            unique case (action)
                ACT_INSERT:
                begin
                    if (full)
                    begin
                        status_next = STATUS_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                ACT_REMOVE:
                begin
                    if (empty)
                    begin
                        status_next = STATUS_EMPTY;
                    end
                    else
                    begin
                        // head cell always holds the maximum
                        removed_value_next = link_w[0].data;
                        count_next         = count_reg - 1'b1;
                    end
                end
                default:
                begin
                    status_next = STATUS_OK;
                end
            endcase
        end

        // occupancy wraps to the field width for large capacities
        occupancy_next = req_fire ? OCC_W'(count_next) : occupancy_reg;
        is_empty_next  = req_fire ? (count_next == '0) : is_empty_reg;
        is_full_next   = req_fire ? (count_next == CAP_CNT) : is_full_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // result payload, held while the transaction is stalled
    always_ff @(posedge clk)
    begin
        removed_value_reg <= removed_value_next;
        status_reg        <= status_next;
        occupancy_reg     <= occupancy_next;
        is_empty_reg      <= is_empty_next;
        is_full_reg       <= is_full_next;
    end

    assign rsp_valid     = rsp_valid_reg;
    assign removed_value = removed_value_reg;
    assign status        = status_reg;
    assign occupancy     = occupancy_reg;
    assign is_empty      = is_empty_reg;
    assign is_full       = is_full_reg;

    // head cell holds a value exactly when the queue is not empty
    `MPQA_ASSERT_NOW(a_head_valid, 1'b1, link_w[0].valid == (count_reg != '0))

    // row stays sorted at its head
    `MPQA_ASSERT_NOW(a_head_sorted, link_w[1].valid,
                     link_w[0].valid && (link_w[0].data >= link_w[1].data))

    // an accepted insert into a non-full queue grows the count by one
    `MPQA_ASSERT_NEXT(a_insert_count, cmd.ins, count_reg == $past(count_reg) + 1'b1)

    // a full rejection is only reported with the full flag set
    `MPQA_ASSERT_NOW(a_full_status, rsp_valid_reg && (status_reg == STATUS_FULL),
                     is_full_reg)

endmodule

`default_nettype wire
